// ----- design/ovts_pkg.sv -----
// Shared types and constants for the overtaking sequencer.
// Holds the one-hot mode type, configuration and result structs, register indexes.
// No dependencies.
package ovts_pkg;

    typedef enum logic [4:0] {
        MODE_FOLLOW     = 5'b00001,
        MODE_TURN_OUT   = 5'b00010,
        MODE_STRAIGHTEN = 5'b00100,
        MODE_TURN_BACK  = 5'b01000,
        MODE_RETURN     = 5'b10000
    } t_mode;

    localparam logic [2:0] MODE_CODE_FOLLOW     = 3'd0;
    localparam logic [2:0] MODE_CODE_TURN_OUT   = 3'd1;
    localparam logic [2:0] MODE_CODE_STRAIGHTEN = 3'd2;
    localparam logic [2:0] MODE_CODE_TURN_BACK  = 3'd3;
    localparam logic [2:0] MODE_CODE_RETURN     = 3'd4;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 14;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CAR_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CRUISE_SPEED = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TURN_ANGLE   = 2'd2;

    localparam logic [10:0] CAR_LENGTH_RST   = 11'd40;
    localparam logic [7:0]  CRUISE_SPEED_RST = 8'd24;
    localparam logic [13:0] TURN_ANGLE_RST   = 14'd4551;

    localparam logic [31:0] PATH_MIN_MM = 32'd300;

    typedef struct packed {
        logic [10:0] car_length;
        logic [7:0]  cruise_speed;
        logic [13:0] turn_angle;
    } t_cfg;

    typedef struct packed {
        logic        heading;
        logic        path;
    } t_take;

    typedef struct packed {
        logic [7:0]         speed_cmd;
        logic signed [15:0] steer_cmd;
        logic [2:0]         mode_now;
    } t_result;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            MODE_FOLLOW:     c = MODE_CODE_FOLLOW;
            MODE_TURN_OUT:   c = MODE_CODE_TURN_OUT;
            MODE_STRAIGHTEN: c = MODE_CODE_STRAIGHTEN;
            MODE_TURN_BACK:  c = MODE_CODE_TURN_BACK;
            MODE_RETURN:     c = MODE_CODE_RETURN;
            default:         c = MODE_CODE_FOLLOW;
        endcase
        return c;
    endfunction

endpackage

// ----- design/ovts_step.sv -----
// Per-frame decision logic: threshold compares, heading change and mode update.
// Purely combinational; state and registers live in the top level.
// Depends on ovts_pkg.
module ovts_step #(
    parameter int ANGLE_BITS = 16,
    parameter int DIST_BITS  = 12
) (
    input  ovts_pkg::t_cfg                i_cfg,
    input  ovts_pkg::t_mode               i_mode,
    input  logic [ANGLE_BITS-1:0]         i_ref_heading,
    input  logic [31:0]                   i_ref_path,
    input  logic                          i_front_sonar_valid,
    input  logic signed [DIST_BITS-1:0]   i_front_sonar_dist,
    input  logic signed [DIST_BITS-1:0]   i_front_ir_dist,
    input  logic signed [DIST_BITS-1:0]   i_right_sonar_dist,
    input  logic [ANGLE_BITS-1:0]         i_heading_now,
    input  logic [31:0]                   i_path_now,
    input  logic signed [15:0]            i_lane_steer,
    output ovts_pkg::t_mode               o_mode,
    output ovts_pkg::t_take               o_take,
    output ovts_pkg::t_result             o_result
);
    import ovts_pkg::*;

    localparam int CW = (DIST_BITS + 3 > 16) ? DIST_BITS + 3 : 16;
    localparam int DW = ANGLE_BITS + 11;
    localparam int DEG1 = ((1 << ANGLE_BITS) + 180) / 360;

    localparam logic signed [ANGLE_BITS:0] HALF_POS = {2'b01, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS:0] HALF_NEG = {2'b11, {(ANGLE_BITS-1){1'b0}}};
    localparam logic signed [ANGLE_BITS:0] FULL_NEG = {1'b1, {ANGLE_BITS{1'b0}}};

    localparam logic signed [DW-1:0] TH_OUT = DW'(8) <<< ANGLE_BITS;
    localparam logic signed [DW-1:0] TH_STR = -(DW'(15) <<< ANGLE_BITS);
    localparam logic signed [DW-1:0] TH_RET = -(DW'(35) <<< ANGLE_BITS);

    logic signed [CW-1:0]         sonar_x, ir_x, right_x, len_x;
    logic signed [CW-1:0]         sonar4, len7, ir2, right4, len5;
    logic signed [ANGLE_BITS:0]   raw_d, d;
    logic signed [DW-1:0]         dx, d360;
    logic [31:0]                  path_d;
    logic [17:0]                  out_mag, out_neg;
    logic signed [15:0]           steer_out;
    logic                         hit_follow, hit_out, hit_str, hit_back, hold_ret;
    logic signed [15:0]           steer;
    logic [7:0]                   speed;
    t_mode                        n_mode;
    t_take                        take;

    always_comb begin
        sonar_x = CW'(i_front_sonar_dist);
        ir_x    = CW'(i_front_ir_dist);
        right_x = CW'(i_right_sonar_dist);
        len_x   = CW'($signed({1'b0, i_cfg.car_length}));
        sonar4  = sonar_x <<< 2;
        len7    = (len_x <<< 3) - len_x;
        ir2     = ir_x <<< 1;
        right4  = right_x <<< 2;
        len5    = (len_x <<< 2) + len_x;

        raw_d = $signed({1'b0, i_heading_now}) - $signed({1'b0, i_ref_heading});
        d     = (raw_d > HALF_POS || raw_d < HALF_NEG) ? raw_d + FULL_NEG : raw_d;
        dx    = DW'(d);
        d360  = (dx <<< 8) + (dx <<< 6) + (dx <<< 5) + (dx <<< 3);

        path_d = i_path_now - i_ref_path;

        out_mag   = 18'(i_cfg.turn_angle) + 18'(DEG1);
        out_neg   = 18'd0 - out_mag;
        steer_out = (out_mag > 18'd32768) ? 16'sh8000 : $signed(out_neg[15:0]);

        hit_follow = (sonar4 < len7) && (sonar_x > 0);
        hit_out    = (ir_x > 0) || (d360 > TH_OUT);
        hit_str    = ((ir2 < len_x) && (ir_x > 0)) || (d360 < TH_STR);
        hit_back   = (path_d > PATH_MIN_MM) && (ir_x < 0) &&
                     ((right4 > len5) || (right_x < 0));
        hold_ret   = d360 > TH_RET;
    end

    always_comb begin
        n_mode       = i_mode;
        take.heading = 1'b0;
        take.path    = 1'b0;
        steer        = 16'sd0;
        speed        = i_cfg.cruise_speed;
        if (i_front_sonar_valid) begin
            unique case (i_mode)
                MODE_FOLLOW: begin
                    steer = i_lane_steer;
                    if (hit_follow) begin
                        take.heading = 1'b1;
                        speed        = 8'd0;
                        n_mode       = MODE_TURN_OUT;
                    end
                end
                MODE_TURN_OUT: begin
                    if (hit_out) begin
                        take.heading = 1'b1;
                        take.path    = 1'b1;
                        n_mode       = MODE_STRAIGHTEN;
                    end else begin
                        steer = steer_out;
                    end
                end
                MODE_STRAIGHTEN: begin
                    if (hit_str) begin
                        take.heading = 1'b1;
                        n_mode       = MODE_TURN_BACK;
                    end else begin
                        steer = $signed({2'b00, i_cfg.turn_angle});
                    end
                end
                MODE_TURN_BACK: begin
                    if (hit_back) begin
                        take.heading = 1'b1;
                        n_mode       = MODE_RETURN;
                    end else begin
                        steer = i_lane_steer;
                    end
                end
                MODE_RETURN: begin
                    if (hold_ret) begin
                        steer = $signed({2'b00, i_cfg.turn_angle});
                    end else begin
                        n_mode = MODE_FOLLOW;
                    end
                end
                default: begin
                    n_mode = i_mode;
                end
            endcase
        end
    end

    assign o_mode             = n_mode;
    assign o_take             = take;
    assign o_result.speed_cmd = speed;
    assign o_result.steer_cmd = steer;
    assign o_result.mode_now  = mode_code(n_mode);

endmodule

// ----- design/overtake_maneuver_sequencer_top.sv -----
// Overtaking sequencer: takes one sensor frame per transaction and returns speed,
// steering and mode in one result transaction. The first result appears in the
// cycle after its frame, and a frame can be taken every cycle unless o_in_stall is
// high: the decision logic sits between the mode/reference registers and a single
// output register, and a new frame is taken while the previous result is being
// delivered. The user must write registers through the plain write port while the
// block is idle; it does not enforce this. Depends on ovts_pkg and ovts_step.
module overtake_maneuver_sequencer_top #(
    parameter int ANGLE_BITS = 16,
    parameter int DIST_BITS  = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ovts_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ovts_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_front_sonar_valid,
    input  logic signed [DIST_BITS-1:0]         i_front_sonar_dist,
    input  logic signed [DIST_BITS-1:0]         i_front_ir_dist,
    input  logic signed [DIST_BITS-1:0]         i_right_sonar_dist,
    input  logic [ANGLE_BITS-1:0]               i_heading_now,
    input  logic [31:0]                         i_path_now,
    input  logic signed [15:0]                  i_lane_steer,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [7:0]                          o_speed_cmd,
    output logic signed [15:0]                  o_steer_cmd,
    output logic [2:0]                          o_mode_now
);
    import ovts_pkg::*;

    t_cfg                   r_cfg;
    t_mode                  r_mode;
    logic [ANGLE_BITS-1:0]  r_ref_heading;
    logic [31:0]            r_ref_path;
    logic                   r_out_valid;
    t_result                r_result;

    t_mode                  n_mode;
    t_take                  n_take;
    t_result                n_result;
    logic                   in_accept;

    ovts_step #(
        .ANGLE_BITS (ANGLE_BITS),
        .DIST_BITS  (DIST_BITS)
    ) u_step (
        .i_cfg               (r_cfg),
        .i_mode              (r_mode),
        .i_ref_heading       (r_ref_heading),
        .i_ref_path          (r_ref_path),
        .i_front_sonar_valid (i_front_sonar_valid),
        .i_front_sonar_dist  (i_front_sonar_dist),
        .i_front_ir_dist     (i_front_ir_dist),
        .i_right_sonar_dist  (i_right_sonar_dist),
        .i_heading_now       (i_heading_now),
        .i_path_now          (i_path_now),
        .i_lane_steer        (i_lane_steer),
        .o_mode              (n_mode),
        .o_take              (n_take),
        .o_result            (n_result)
    );

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.car_length   <= CAR_LENGTH_RST;
            r_cfg.cruise_speed <= CRUISE_SPEED_RST;
            r_cfg.turn_angle   <= TURN_ANGLE_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CAR_LENGTH:   r_cfg.car_length   <= i_cfg_wdata[10:0];
                CFG_CRUISE_SPEED: r_cfg.cruise_speed <= i_cfg_wdata[7:0];
                CFG_TURN_ANGLE:   r_cfg.turn_angle   <= i_cfg_wdata[13:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_FOLLOW;
            r_ref_heading <= '0;
            r_ref_path    <= '0;
        end else if (in_accept) begin
            r_mode <= n_mode;
            if (n_take.heading) begin
                r_ref_heading <= i_heading_now;
            end
            if (n_take.path) begin
                r_ref_path <= i_path_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_speed_cmd = r_result.speed_cmd;
    assign o_steer_cmd = r_result.steer_cmd;
    assign o_mode_now  = r_result.mode_now;

endmodule
